[rtl/stride_sequence_allocator_table_macros.svh]
// assertion helpers for the sequence table
`ifndef STRIDE_SEQUENCE_ALLOCATOR_TABLE_MACROS_SVH
`define STRIDE_SEQUENCE_ALLOCATOR_TABLE_MACROS_SVH

// implication checked every cycle outside reset
`define SSAT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define SSAT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/ssat_pkg.sv]
`default_nettype none
package ssat_pkg;

  localparam int unsigned ENTRIES_DEF = 64;
  localparam int unsigned VW = 63;

  // operation codes
  localparam logic [2:0] OP_CREATE = 3'd0;
  localparam logic [2:0] OP_UPDATE = 3'd1;
  localparam logic [2:0] OP_GEN    = 3'd2;
  localparam logic [2:0] OP_DELETE = 3'd3;
  localparam logic [2:0] OP_QUERY  = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_EXISTS    = 3'd2;
  localparam logic [2:0] ST_ILLEGAL   = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_OVERFLOW  = 3'd5;

  // register indexes
  localparam logic REG_MAX_STRIDE = 1'b0;
  localparam logic REG_MAX_COUNT  = 1'b1;

  typedef struct packed {
    logic [2:0]    operation;
    logic [VW-1:0] table_key;
    logic [VW-1:0] new_value;
    logic          force_req;
    logic [15:0]   count;
    logic [15:0]   stride;
    logic [15:0]   start_offset;
  } ssat_in_t;

  typedef struct packed {
    logic [2:0]    status;
    logic [VW-1:0] range_start;
    logic [VW-1:0] range_end;
  } ssat_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request, clear search
    logic scan;      // look at one entry
    logic div_start;
    logic div_step;
    logic finish;    // compute result and write back
  } ssat_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic need_div;
    logic div_last;
  } ssat_sts_t;

endpackage
`default_nettype wire

[rtl/ssat_ctrl.sv]
`default_nettype none
module ssat_ctrl
  import ssat_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  input  wire ssat_sts_t  sts,
  output ssat_cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_DIV  = 5'b00100,
    S_FIN  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          if (sts.need_div) begin
            cmd.div_start = 1'b1;
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule
`default_nettype wire

[rtl/ssat_dp.sv]
`default_nettype none
// generic single-port-write memory with registered read
module ssat_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

module ssat_dp
  import ssat_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire ssat_in_t   in_data,
  input  wire ssat_cmd_t  cmd,
  output ssat_sts_t       sts,
  output ssat_out_t       out_data
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [15:0] max_stride_r, max_count_r;
  ssat_in_t    req_r;
  logic [ENTRIES-1:0] valid_r;

  logic [IW-1:0] scan_idx_r;
  logic          hit_r, free_found_r;
  logic [IW-1:0] hit_idx_r, free_idx_r;
  logic [VW-1:0] cur_r;
  ssat_out_t     out_r;

  // divider state: remainder of cur by stride, restoring
  logic [VW-1:0] div_q_r;
  logic [16:0]   div_rem_r;
  logic [5:0]    div_cnt_r;
  logic [15:0]   off_eff;

  // table memory ports
  logic [IW-1:0] rd_addr;
  logic [VW-1:0] key_rd, next_rd;
  logic          key_ins, next_upd;
  logic [IW-1:0] next_waddr;
  logic [VW-1:0] next_wdata;
  ssat_out_t     out_nxt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_stride_r <= 16'hffff;
      max_count_r  <= 16'hffff;
    end else if (cfg_we) begin
      if (cfg_index == REG_MAX_STRIDE) max_stride_r <= cfg_wdata;
      else                             max_count_r  <= cfg_wdata;
    end
  end

  // parameter legality for generate
  logic gen_ok;
  assign gen_ok = (req_r.count != 16'd0) && (req_r.count <= max_count_r) &&
                  (req_r.stride != 16'd0) && (req_r.stride <= max_stride_r) &&
                  (req_r.start_offset != 16'd0) && (req_r.start_offset <= max_stride_r);
  assign off_eff = (req_r.start_offset > req_r.stride) ? 16'd1 : req_r.start_offset;

  // read one entry ahead so the registered data lines up with scan_idx_r
  assign rd_addr = cmd.load ? '0 :
                   (cmd.scan && !sts.scan_last) ? scan_idx_r + 1'b1 : scan_idx_r;

  // key and counter storage
  ssat_ram #(.WIDTH(VW), .DEPTH(ENTRIES)) u_key_ram (
    .clk, .we(cmd.finish && key_ins), .waddr(free_idx_r), .wdata(req_r.table_key),
    .raddr(rd_addr), .rdata(key_rd)
  );

  ssat_ram #(.WIDTH(VW), .DEPTH(ENTRIES)) u_next_ram (
    .clk, .we(cmd.finish && next_upd), .waddr(next_waddr), .wdata(next_wdata),
    .raddr(rd_addr), .rdata(next_rd)
  );

  logic scan_hit;
  assign scan_hit = valid_r[scan_idx_r] && (key_rd == req_r.table_key);

  assign sts.scan_last = (scan_idx_r == IW'(ENTRIES - 1));
  assign sts.need_div  = (req_r.operation == OP_GEN) && (hit_r || scan_hit) && gen_ok &&
                         !(req_r.stride == 16'd1 && off_eff == 16'd1);
  assign sts.div_last  = (div_cnt_r == 6'd0);

  // restoring remainder step
  logic [16:0] rem_sh;
  assign rem_sh = {div_rem_r[15:0], div_q_r[VW-1]};

  // end computation from remainder
  logic [VW:0] first, prod, end_val;
  logic [15:0] rem16;
  assign rem16 = div_rem_r[15:0];
  always_comb begin
    if (rem16 < off_eff)      first = {1'b0, cur_r} - {48'd0, rem16} + {48'd0, off_eff};
    else if (rem16 > off_eff) first = {1'b0, cur_r} - {48'd0, rem16} +
                                      {48'd0, req_r.stride} + {48'd0, off_eff};
    else                      first = {1'b0, cur_r};
    prod = {32'd0, 32'(req_r.count) * 32'(req_r.stride)};
    if (req_r.stride == 16'd1 && off_eff == 16'd1)
      end_val = {1'b0, cur_r} + {48'd0, req_r.count};
    else
      end_val = first + prod;
  end

  // result and table write back
  always_comb begin
    out_nxt    = '0;
    key_ins    = 1'b0;
    next_upd   = 1'b0;
    next_waddr = hit_idx_r;
    next_wdata = req_r.new_value;
    case (req_r.operation)
      OP_CREATE: begin
        if (hit_r) out_nxt.status = (cur_r == req_r.new_value) ? ST_OK : ST_EXISTS;
        else if (!free_found_r) out_nxt.status = ST_FULL;
        else begin
          key_ins    = 1'b1;
          next_upd   = 1'b1;
          next_waddr = free_idx_r;
        end
      end
      OP_UPDATE: begin
        if (!hit_r) out_nxt.status = ST_NOT_FOUND;
        else if (req_r.new_value <= cur_r && !req_r.force_req) out_nxt.status = ST_ILLEGAL;
        else begin
          out_nxt.range_start = cur_r;
          next_upd            = 1'b1;
        end
      end
      OP_GEN: begin
        if (!hit_r) out_nxt.status = ST_NOT_FOUND;
        else if (!gen_ok) out_nxt.status = ST_ILLEGAL;
        else if (end_val[VW]) out_nxt.status = ST_OVERFLOW;
        else begin
          out_nxt.range_start = cur_r;
          out_nxt.range_end   = end_val[VW-1:0];
          next_upd            = 1'b1;
          next_wdata          = end_val[VW-1:0];
        end
      end
      OP_DELETE: ;
      OP_QUERY: begin
        if (!hit_r) out_nxt.status = ST_NOT_FOUND;
        else out_nxt.range_start = cur_r;
      end
      default: out_nxt.status = ST_ILLEGAL;
    endcase
  end

  // entry valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.finish) begin
      case (req_r.operation)
        OP_CREATE: if (!hit_r && free_found_r) valid_r[free_idx_r] <= 1'b1;
        OP_DELETE: if (hit_r) valid_r[hit_idx_r] <= 1'b0;
        default: ;
      endcase
    end
  end

  // search, divide and result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r        <= in_data;
      scan_idx_r   <= '0;
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
    end
    if (cmd.scan) begin
      if (!sts.scan_last) scan_idx_r <= scan_idx_r + 1'b1;
      if (scan_hit && !hit_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= scan_idx_r;
        cur_r     <= next_rd;
      end
      if (!valid_r[scan_idx_r] && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= scan_idx_r;
      end
    end
    if (cmd.div_start) begin
      div_q_r   <= hit_r ? cur_r : next_rd;
      div_rem_r <= '0;
      div_cnt_r <= 6'(VW - 1);
    end
    if (cmd.div_step) begin
      div_q_r <= {div_q_r[VW-2:0], 1'b0};
      if (rem_sh >= {1'b0, req_r.stride}) div_rem_r <= rem_sh - {1'b0, req_r.stride};
      else                                div_rem_r <= rem_sh;
      if (div_cnt_r != 6'd0) div_cnt_r <= div_cnt_r - 1'b1;
    end
    if (cmd.finish) out_r <= out_nxt;
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

[rtl/stride_sequence_allocator_table.sv]
// channel | ports                          | payload
// request | in_valid / in_stall / in_data  | ssat_in_t
// result  | out_valid / out_stall / out_data | ssat_out_t
// config  | cfg_we / cfg_index / cfg_wdata | 16-bit register value
// a generate that needs the bit-serial remainder runs it after the key
// search; the key search visits one entry a cycle
// one request in flight; in_stall is high from acceptance until the result is taken
// reset is synchronous, active low, and empties the table at once
`default_nettype none
module stride_sequence_allocator_table
  import ssat_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire ssat_in_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output ssat_out_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata
);
`include "stride_sequence_allocator_table_macros.svh"

  ssat_cmd_t cmd;
  ssat_sts_t sts;

  // sequencing
  ssat_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  // table and arithmetic
  ssat_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata, .in_data, .cmd, .sts, .out_data
  );

  `SSAT_ASSERT_IMP(a_load_idle, clk, rst_n, cmd.load, !in_stall)
  `SSAT_ASSERT_NXT(a_fin_out, clk, rst_n, cmd.finish, out_valid)
  `SSAT_ASSERT_IMP(a_out_busy, clk, rst_n, out_valid, in_stall)

endmodule
`default_nettype wire

[bench/tb.sv]
`default_nettype none
module tb;
  import ssat_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  ssat_in_t in_data;
  logic out_valid;
  logic out_stall;
  ssat_out_t out_data;
  logic cfg_we;
  logic cfg_index;
  logic [15:0] cfg_wdata;

  stride_sequence_allocator_table dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  localparam int NSLOT = 64;
  localparam int LIMIT = 3000000;
  localparam logic [63:0] MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;

  // predictor copy of the counter table and registers
  logic [15:0] lim_stride;
  logic [15:0] lim_count;
  logic        slot_used [NSLOT];
  logic [62:0] slot_key [NSLOT];
  logic [62:0] slot_next [NSLOT];

  ssat_out_t   pending_results[$];
  int          errors;
  int          cycle_cnt;
  int          got_cnt;
  int          sent_cnt;
  int          snd_idle_pct;
  int          rcv_stall_pct;
  logic        hold_off;
  logic [62:0] key_pool [8];

  // directed request table; exp_st of -1 means use the predictor only
  typedef struct {
    logic [2:0]  op;
    logic [62:0] key;
    logic [62:0] val;
    logic        frc;
    logic [15:0] cnt;
    logic [15:0] str;
    logic [15:0] off;
    int          exp_st;
  } row_t;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // end value of a generate: first id on the stride grid, then count steps
  function automatic logic [63:0] range_end_of(logic [62:0] base, logic [15:0] n,
                                                logic [15:0] step, logic [15:0] ofs);
    logic [63:0] rem;
    logic [63:0] first;
    logic [15:0] o;
    o = (ofs > step) ? 16'd1 : ofs;
    if (step == 16'd1 && o == 16'd1) return {1'b0, base} + 64'(n);
    rem = {1'b0, base} % 64'(step);
    if (rem < 64'(o)) first = {1'b0, base} - rem + 64'(o);
    else if (rem > 64'(o)) first = {1'b0, base} - rem + 64'(step) + 64'(o);
    else first = {1'b0, base};
    return first + 64'(n) * 64'(step);
  endfunction

  // table update and expected result for one request
  function automatic ssat_out_t predict_table(ssat_in_t r);
    ssat_out_t res;
    int idx;
    int fre;
    logic [63:0] e;
    res = '0;
    idx = -1;
    fre = -1;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (slot_used[i] && slot_key[i] == r.table_key) idx = i;
      if (!slot_used[i]) fre = i;
    end
    res.status = ST_OK;
    case (r.operation)
      OP_CREATE: begin
        if (idx >= 0) begin
          if (slot_next[idx] != r.new_value) res.status = ST_EXISTS;
        end else if (fre < 0) begin
          res.status = ST_FULL;
        end else begin
          slot_used[fre] = 1'b1;
          slot_key[fre] = r.table_key;
          slot_next[fre] = r.new_value;
        end
      end
      OP_UPDATE: begin
        if (idx < 0) res.status = ST_NOT_FOUND;
        else if (r.new_value <= slot_next[idx] && !r.force_req) res.status = ST_ILLEGAL;
        else begin
          res.range_start = slot_next[idx];
          slot_next[idx] = r.new_value;
        end
      end
      OP_GEN: begin
        if (idx < 0) res.status = ST_NOT_FOUND;
        else if (r.count == 0 || r.count > lim_count || r.stride == 0 ||
                 r.stride > lim_stride || r.start_offset == 0 ||
                 r.start_offset > lim_stride) res.status = ST_ILLEGAL;
        else begin
          e = range_end_of(slot_next[idx], r.count, r.stride, r.start_offset);
          if (e > MAX63) res.status = ST_OVERFLOW;
          else begin
            res.range_start = slot_next[idx];
            res.range_end = e[62:0];
            slot_next[idx] = e[62:0];
          end
        end
      end
      OP_DELETE: begin
        if (idx >= 0) slot_used[idx] = 1'b0;
      end
      OP_QUERY: begin
        if (idx < 0) res.status = ST_NOT_FOUND;
        else res.range_start = slot_next[idx];
      end
      default: res.status = ST_ILLEGAL;
    endcase
    return res;
  endfunction

  // offer one request and wait for acceptance
  task automatic send_request(ssat_in_t r, int exp_st);
    ssat_out_t res;
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = predict_table(r);
    if (exp_st >= 0 && res.status != 3'(exp_st)) begin
      $error("status: expected %0d actual %0d", exp_st, res.status);
      errors++;
    end
    pending_results.push_back(res);
    sent_cnt++;
  endtask

  // wait for the block to drain, then write a register
  task automatic write_reg(logic idx, logic [15:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MAX_STRIDE) lim_stride = v;
    else lim_count = v;
  endtask

  // random request, mostly on a small pool of keys
  function automatic ssat_in_t random_request();
    ssat_in_t r;
    int k;
    r.operation = 3'($urandom_range(99) < 4 ? $urandom_range(7) : $urandom_range(4));
    if ($urandom_range(99) < 45 && r.operation != OP_CREATE) r.operation = OP_GEN;
    k = $urandom_range(7);
    r.table_key = ($urandom_range(99) < 85) ? key_pool[k] : 63'({$urandom, $urandom});
    case ($urandom_range(3))
      0: r.new_value = 63'($urandom_range(1000));
      1: r.new_value = 63'({$urandom, $urandom});
      2: r.new_value = MAX63[62:0] - 63'($urandom_range(100000));
      default: r.new_value = 63'({$urandom, $urandom}) >> $urandom_range(62);
    endcase
    r.force_req = 1'($urandom);
    r.count = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(20));
    r.stride = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(12));
    r.start_offset = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(14));
    return r;
  endfunction

  // result checking
  always @(posedge clk) begin
    ssat_out_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      got_cnt <= got_cnt + 1;
      if (pending_results.size() == 0) begin
        $error("result with no request pending");
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data.status != exp_r.status) begin
          $error("status: expected %0d actual %0d", exp_r.status, out_data.status);
          errors++;
        end
        if (out_data.range_start != exp_r.range_start) begin
          $error("range_start: expected %0h actual %0h", exp_r.range_start,
                 out_data.range_start);
          errors++;
        end
        if (out_data.range_end != exp_r.range_end) begin
          $error("range_end: expected %0h actual %0h", exp_r.range_end,
                 out_data.range_end);
          errors++;
        end
      end
    end
  end

  // receiver stalls, plus a long hold-off when asked
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < rcv_stall_pct);
  end

  initial begin
    row_t rows[$];
    ssat_in_t r;
    int phase_items;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_MAX_STRIDE;
    cfg_wdata = '0;
    errors = 0;
    cycle_cnt = 0;
    got_cnt = 0;
    sent_cnt = 0;
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    hold_off = 1'b0;
    lim_stride = 16'hFFFF;
    lim_count = 16'hFFFF;
    for (int i = 0; i < NSLOT; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i] = '0;
      slot_next[i] = '0;
    end
    for (int i = 0; i < 8; i++) key_pool[i] = 63'({$urandom, $urandom});
    key_pool[0] = '0;
    key_pool[1] = MAX63[62:0];
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, every operation and the listed corner cases
    rows = '{
      '{OP_QUERY,  63'd5, 63'd0, 1'b0, 16'd0, 16'd0, 16'd0, ST_NOT_FOUND},
      '{OP_UPDATE, 63'd5, 63'd9, 1'b0, 16'd0, 16'd0, 16'd0, ST_NOT_FOUND},
      '{OP_GEN,    63'd5, 63'd0, 1'b0, 16'd0, 16'd0, 16'd0, ST_NOT_FOUND},
      '{OP_DELETE, 63'd5, 63'd0, 1'b0, 16'd0, 16'd0, 16'd0, ST_OK},
      '{OP_CREATE, 63'd0, 63'd0, 1'b0, 16'd0, 16'd0, 16'd0, ST_OK},
      '{OP_CREATE, MAX63[62:0], MAX63[62:0] - 63'd20, 1'b0, 16'd0, 16'd0, 16'd0, ST_OK},
      '{OP_CREATE, 63'd0, 63'd0, 1'b0, 16'd0, 16'd0, 16'd0, ST_OK},
      '{OP_CREATE, 63'd0, 63'd7, 1'b0, 16'd0, 16'd0, 16'd0, ST_EXISTS},
      '{OP_GEN,    63'd0, 63'd0, 1'b0, 16'd0, 16'd1, 16'd1, ST_ILLEGAL},
      '{OP_GEN,    63'd0, 63'd0, 1'b0, 16'd1, 16'd0, 16'd1, ST_ILLEGAL},
      '{OP_GEN,    63'd0, 63'd0, 1'b0, 16'd1, 16'd1, 16'd0, ST_ILLEGAL},
      '{OP_GEN,    63'd0, 63'd0, 1'b0, 16'd10, 16'd1, 16'd1, ST_OK},
      '{OP_GEN,    63'd0, 63'd0, 1'b0, 16'd3, 16'd4, 16'd9, -1},
      '{OP_GEN,    63'd0, 63'd0, 1'b0, 16'd2, 16'd5, 16'd3, -1},
      '{OP_GEN,    63'd0, 63'd0, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, -1},
      '{OP_UPDATE, 63'd0, 63'd1, 1'b0, 16'd0, 16'd0, 16'd0, ST_ILLEGAL},
      '{OP_UPDATE, 63'd0, 63'd1, 1'b1, 16'd0, 16'd0, 16'd0, -1},
      '{OP_UPDATE, 63'd0, 63'd900, 1'b0, 16'd0, 16'd0, 16'd0, -1},
      '{OP_GEN,    MAX63[62:0], 63'd0, 1'b0, 16'd100, 16'd1, 16'd1, ST_OVERFLOW},
      '{OP_GEN,    MAX63[62:0], 63'd0, 1'b0, 16'd20, 16'd1, 16'd1, -1},
      '{OP_QUERY,  MAX63[62:0], 63'd0, 1'b0, 16'd0, 16'd0, 16'd0, -1},
      '{3'd5,      63'd0, 63'd0, 1'b0, 16'd0, 16'd0, 16'd0, ST_ILLEGAL},
      '{3'd7,      63'd0, 63'd0, 1'b1, 16'd0, 16'd0, 16'd0, ST_ILLEGAL},
      '{OP_DELETE, MAX63[62:0], 63'd0, 1'b0, 16'd0, 16'd0, 16'd0, ST_OK},
      '{OP_QUERY,  MAX63[62:0], 63'd0, 1'b0, 16'd0, 16'd0, 16'd0, ST_NOT_FOUND}
    };
    foreach (rows[i]) begin
      r.operation = rows[i].op;
      r.table_key = rows[i].key;
      r.new_value = rows[i].val;
      r.force_req = rows[i].frc;
      r.count = rows[i].cnt;
      r.stride = rows[i].str;
      r.start_offset = rows[i].off;
      send_request(r, rows[i].exp_st);
    end

    // fill the table to reach the full status
    for (int i = 0; i < NSLOT; i++) begin
      r = '0;
      r.operation = OP_CREATE;
      r.table_key = 63'(1000 + i);
      r.new_value = 63'(i);
      send_request(r, -1);
    end
    r.table_key = 63'd99999;
    send_request(r, ST_FULL);
    for (int i = 0; i < NSLOT; i++) begin
      r = '0;
      r.operation = OP_DELETE;
      r.table_key = 63'(1000 + i);
      send_request(r, -1);
    end

    // random phases over idle mixes and register settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 82; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 82; end
        default: begin snd_idle_pct = 28; rcv_stall_pct = 28; end
      endcase
      case (ph)
        2: begin write_reg(REG_MAX_STRIDE, 16'd1); write_reg(REG_MAX_COUNT, 16'd1); end
        4: begin write_reg(REG_MAX_STRIDE, 16'd8); write_reg(REG_MAX_COUNT, 16'd12); end
        6: begin write_reg(REG_MAX_STRIDE, 16'hFFFF); write_reg(REG_MAX_COUNT, 16'hFFFF); end
        default: ;
      endcase
      // long receiver hold-off while requests keep coming
      if (ph == 1) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (600) @(negedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      phase_items = 225;
      for (int n = 0; n < phase_items; n++) begin
        r = random_request();
        // seed creates so keys exist for deeper operations
        if (n % 12 == 0) begin
          r.operation = OP_CREATE;
          r.table_key = key_pool[$urandom_range(7)];
        end
        send_request(r, -1);
      end
    end

    // drain
    @(negedge clk);
    in_valid <= 1'b0;
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("sent %0d requests, checked %0d results over four idle mixes", sent_cnt,
             got_cnt);
    $display("register settings covered min, mid and max limits");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
